>>> src/mwc_pkg.sv
// Shared types and constants of the medication alarm window controller.
package mwc_pkg;

    // Event kinds carried in the input tuser.
    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_BUTTON = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Reply codes given by the entry machine.
    localparam logic [2:0] REPLY_NONE       = 3'd0;
    localparam logic [2:0] REPLY_ASK_HOUR   = 3'd1;
    localparam logic [2:0] REPLY_ENTER_HOUR = 3'd2;
    localparam logic [2:0] REPLY_ASK_MINUTE = 3'd3;
    localparam logic [2:0] REPLY_ENTER_MIN  = 3'd4;
    localparam logic [2:0] REPLY_ASK_CONF   = 3'd5;
    localparam logic [2:0] REPLY_DONE       = 3'd6;

    // Characters of the alarm entry dialogue.
    localparam logic [7:0] CHAR_S = 8'h53;
    localparam logic [7:0] CHAR_H = 8'h48;
    localparam logic [7:0] CHAR_M = 8'h4D;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;

    // Lamp commands.
    localparam logic [1:0] LAMP_KEEP = 2'd0;
    localparam logic [1:0] LAMP_ON   = 2'd1;
    localparam logic [1:0] LAMP_OFF  = 2'd2;

    // Minutes in one day.
    localparam logic [11:0] DAY_MINUTES = 12'd1440;

    // Configuration register byte addresses (bit 2 selects the register).
    localparam int unsigned CFG_ADDR_W = 3;

    // Result of the entry machine for one request.
    typedef struct packed {
        logic [2:0] reply_code;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic [2:0] entry_phase;
    } t_entry_res;

    // Commands of the window logic for one request.
    typedef struct packed {
        logic       start_music;
        logic       pause_music;
        logic       send_sms;
        logic [1:0] lamp_action;
        logic       box_open;
    } t_win_cmd;

endpackage

>>> src/mwc_cfg.sv
// Configuration registers of the controller behind an APB-style port.
module mwc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mwc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output logic [9:0]                       o_half_window,
    output logic [5:0]                       o_grace
);
    import mwc_pkg::*;

    logic [9:0] r_half;
    logic [5:0] r_grace;
    logic       w_write;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite && pready;

    // Register writes; bit 2 of the address picks the register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= 10'd30;
            r_grace <= 6'd3;
        end else if (w_write) begin
            if (paddr[2]) begin
                r_grace <= pwdata[5:0];
            end else begin
                r_half <= pwdata[9:0];
            end
        end
    end

    // Read data follows the addressed register.
    assign prdata = paddr[2] ? {26'd0, r_grace} : {22'd0, r_half};

    assign o_half_window = r_half;
    assign o_grace       = r_grace;

endmodule

>>> src/mwc_entry.sv
// Alarm entry state machine: steps on received bytes and holds the alarm time.
module mwc_entry (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [1:0]             i_op,
    input  logic [7:0]             i_rx_byte,
    output logic [4:0]             o_alarm_hour,
    output logic [5:0]             o_alarm_minute,
    output logic                   o_idle,
    output mwc_pkg::t_entry_res    o_res
);
    import mwc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WANT_H,
        ST_HOUR_TENS,
        ST_HOUR_UNITS,
        ST_WANT_M,
        ST_MIN_TENS,
        ST_MIN_UNITS,
        ST_WANT_C
    } t_entry_state;

    t_entry_state r_state, n_state;
    logic [4:0]   r_hour, n_hour;
    logic [5:0]   r_minute, n_minute;
    logic [2:0]   w_reply;
    logic [3:0]   w_digit;
    logic         w_is_digit;
    logic         w_byte;

    assign w_byte     = i_fire && (i_op == OP_BYTE);
    assign w_digit    = 4'(i_rx_byte - CHAR_0);
    assign w_is_digit = (i_rx_byte >= CHAR_0) && (i_rx_byte <= CHAR_9);

    // Next state of the entry machine for a received byte.
    always_comb begin
        n_state  = r_state;
        n_hour   = r_hour;
        n_minute = r_minute;
        w_reply  = REPLY_NONE;
        if (w_byte) begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_rx_byte == CHAR_S) begin
                        n_hour   = 5'd0;
                        n_minute = 6'd0;
                        n_state  = ST_WANT_H;
                        w_reply  = REPLY_ASK_HOUR;
                    end
                end
                ST_WANT_H: begin
                    if (i_rx_byte == CHAR_H) begin
                        n_state = ST_HOUR_TENS;
                        w_reply = REPLY_ENTER_HOUR;
                    end
                end
                ST_HOUR_TENS: begin
                    if (w_is_digit && w_digit <= 4'd2) begin
                        n_hour  = 5'(w_digit);
                        n_state = ST_HOUR_UNITS;
                    end
                end
                ST_HOUR_UNITS: begin
                    if (w_is_digit && ((r_hour == 5'd2 && w_digit <= 4'd3) ||
                                       r_hour < 5'd2)) begin
                        n_hour  = 5'(r_hour * 4'd10 + 5'(w_digit));
                        n_state = ST_WANT_M;
                        w_reply = REPLY_ASK_MINUTE;
                    end
                end
                ST_WANT_M: begin
                    if (i_rx_byte == CHAR_M) begin
                        n_state = ST_MIN_TENS;
                        w_reply = REPLY_ENTER_MIN;
                    end
                end
                ST_MIN_TENS: begin
                    if (w_is_digit && w_digit <= 4'd5) begin
                        n_minute = 6'(w_digit);
                        n_state  = ST_MIN_UNITS;
                    end
                end
                ST_MIN_UNITS: begin
                    if (w_is_digit) begin
                        n_minute = 6'(r_minute * 4'd10 + 6'(w_digit));
                        n_state  = ST_WANT_C;
                        w_reply  = REPLY_ASK_CONF;
                    end
                end
                ST_WANT_C: begin
                    if (i_rx_byte == CHAR_C) begin
                        n_state = ST_IDLE;
                        w_reply = REPLY_DONE;
                    end
                end
            endcase
        end
    end

    // State and stored alarm time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_hour   <= 5'd14;
            r_minute <= 6'd31;
        end else begin
            r_state  <= n_state;
            r_hour   <= n_hour;
            r_minute <= n_minute;
        end
    end

    assign o_alarm_hour   = r_hour;
    assign o_alarm_minute = r_minute;
    assign o_idle         = (r_state == ST_IDLE);

    assign o_res.reply_code   = w_reply;
    assign o_res.alarm_hour   = n_hour;
    assign o_res.alarm_minute = n_minute;
    assign o_res.entry_phase  = n_state;

`ifndef SYNTHESIS
    // Once the hour digits are complete the hour is a valid clock hour.
    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WANT_M) |-> (r_hour <= 5'd23))
        else $error("entry: alarm hour out of range after hour entry");
`endif

endmodule

>>> src/mwc_window.sv
// Window checks on ticks and button presses, with the reminder flags.
module mwc_window (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [1:0]           i_op,
    input  logic [4:0]           i_cur_hour,
    input  logic [5:0]           i_cur_minute,
    input  logic                 i_music_playing,
    input  logic [4:0]           i_alarm_hour,
    input  logic [5:0]           i_alarm_minute,
    input  logic                 i_entry_idle,
    input  logic [9:0]           i_half_window,
    input  logic [5:0]           i_grace,
    output mwc_pkg::t_win_cmd    o_cmd
);
    import mwc_pkg::*;

    logic [10:0] r_now, n_now;
    logic        r_opened, n_opened;
    logic        r_done, n_done;
    logic        r_music_warned, n_music_warned;
    logic        r_sms_warned, n_sms_warned;

    logic [10:0] w_set, w_lower, w_upper, w_tend, w_now_tick;
    logic [11:0] w_up_sum, w_end_sum;
    logic        w_tick_valid, w_tick_music, w_btn_valid, w_btn_music;
    logic        w_start, w_pause, w_sms;
    logic [1:0]  w_lamp;

    // Range test; a range wraps past midnight if its start is above its end (strict: not below).
    function automatic logic in_range(input logic [10:0] now, input logic [10:0] a,
                                      input logic [10:0] b, input logic strict);
        logic plain;
        plain = strict ? (a < b) : (a <= b);
        if (plain) begin
            return (now >= a) && (now <= b);
        end
        return (now >= a) || (now <= b);
    endfunction

    // Window bounds from the stored alarm time.
    assign w_set   = 11'(i_alarm_hour) * 11'd60 + 11'(i_alarm_minute);
    assign w_lower = (w_set < 11'(i_half_window)) ?
                     11'(12'(w_set) + DAY_MINUTES - 12'(i_half_window)) :
                     11'(w_set - 11'(i_half_window));
    assign w_up_sum  = 12'(w_set) + 12'(i_half_window);
    assign w_upper   = (w_up_sum >= DAY_MINUTES) ? 11'(w_up_sum - DAY_MINUTES) : 11'(w_up_sum);
    assign w_end_sum = 12'(w_upper) + 12'(i_grace);
    assign w_tend    = (w_end_sum >= DAY_MINUTES) ? 11'(w_end_sum - DAY_MINUTES) :
                       11'(w_end_sum);

    // Wall time of a tick in minutes.
    assign w_now_tick = 11'(i_cur_hour) * 11'd60 + 11'(i_cur_minute);

    assign w_tick_valid = in_range(w_now_tick, w_lower, w_tend, 1'b1);
    assign w_tick_music = in_range(w_now_tick, w_set, w_upper, 1'b1);
    assign w_btn_valid  = in_range(r_now, w_lower, w_upper, 1'b0);
    assign w_btn_music  = in_range(r_now, w_set, w_upper, 1'b1);

    // Commands and flag updates for one request.
    always_comb begin
        n_now          = r_now;
        n_opened       = r_opened;
        n_done         = r_done;
        n_music_warned = r_music_warned;
        n_sms_warned   = r_sms_warned;
        w_start        = 1'b0;
        w_pause        = 1'b0;
        w_sms          = 1'b0;
        w_lamp         = LAMP_KEEP;
        if (i_fire) begin
            case (i_op)
                OP_TICK: begin
                    n_now = w_now_tick;
                    if (i_entry_idle) begin
                        if (w_tick_valid) begin
                            if (r_opened || r_done) begin
                                w_pause = r_music_warned;
                            end else if (w_tick_music && !r_music_warned) begin
                                w_start        = 1'b1;
                                n_music_warned = 1'b1;
                            end else if (w_now_tick > w_upper && !r_sms_warned) begin
                                w_pause      = 1'b1;
                                w_lamp       = LAMP_ON;
                                w_sms        = 1'b1;
                                n_sms_warned = 1'b1;
                            end
                        end else begin
                            w_lamp         = LAMP_OFF;
                            n_opened       = 1'b0;
                            n_music_warned = 1'b0;
                            n_sms_warned   = 1'b0;
                            n_done         = 1'b0;
                        end
                    end
                end
                OP_BUTTON: begin
                    if (w_btn_valid) begin
                        n_opened = 1'b1;
                        n_done   = 1'b1;
                        w_lamp   = LAMP_ON;
                        if (w_btn_music && i_music_playing) begin
                            w_pause        = 1'b1;
                            n_music_warned = 1'b1;
                        end
                    end else begin
                        n_opened = 1'b0;
                        w_lamp   = LAMP_OFF;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Wall time and reminder flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now          <= 11'd0;
            r_opened       <= 1'b0;
            r_done         <= 1'b0;
            r_music_warned <= 1'b0;
            r_sms_warned   <= 1'b0;
        end else begin
            r_now          <= n_now;
            r_opened       <= n_opened;
            r_done         <= n_done;
            r_music_warned <= n_music_warned;
            r_sms_warned   <= n_sms_warned;
        end
    end

    assign o_cmd.start_music = w_start;
    assign o_cmd.pause_music = w_pause;
    assign o_cmd.send_sms    = w_sms;
    assign o_cmd.lamp_action = w_lamp;
    assign o_cmd.box_open    = n_opened;

`ifndef SYNTHESIS
    // A reminder message is sent once and then remembered.
    a_sms_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_sms) |=> r_sms_warned)
        else $error("window: reminder flag not set after message");
    // A reminder message always comes with the lamp on and the music paused.
    a_sms_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sms |-> (w_lamp == LAMP_ON && w_pause && !w_start))
        else $error("window: reminder without lamp and pause");
`endif

endmodule

>>> src/medication_alarm_window_controller_top.sv
// Top level of the medication alarm window controller.
// A request waits in the input register, and its result in the result register.
// Throughput: one request per cycle; the input register and the result register
// both advance whenever the result register is empty or being taken.
// All work for a request is one pass of logic between these two registers.
// Reset (synchronous, active low) empties both registers, idles the entry
// machine, sets the alarm to 14:31 and the window registers to 30 and 3 minutes.
module medication_alarm_window_controller_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] rx_byte, [12:8] cur_hour, [18:13] cur_minute, [19] music_playing
    input  logic [23:0]                    s_axis_tdata,
    // [1:0] op
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [2:0] reply_code, [7:3] alarm_hour_out, [13:8] alarm_minute_out,
    // [16:14] entry_phase, [17] start_music, [18] pause_music, [19] send_sms,
    // [21:20] lamp_action, [22] box_open
    output logic [23:0]                    m_axis_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mwc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import mwc_pkg::*;

    logic        r_in_valid;
    logic [23:0] r_in_data;
    logic [1:0]  r_in_op;
    logic        r_out_valid;
    logic [23:0] r_out_data;
    logic        w_advance, w_fire;

    logic [9:0]  w_half;
    logic [5:0]  w_grace;
    logic [4:0]  w_alarm_hour;
    logic [5:0]  w_alarm_minute;
    logic        w_entry_idle;
    t_entry_res  w_entry_res;
    t_win_cmd    w_cmd;

    // Handshake: the input register moves on whenever the result register can.
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
            r_in_op   <= s_axis_tuser;
        end
    end

    mwc_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_half_window (w_half),
        .o_grace       (w_grace)
    );

    mwc_entry u_entry (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_op           (r_in_op),
        .i_rx_byte      (r_in_data[7:0]),
        .o_alarm_hour   (w_alarm_hour),
        .o_alarm_minute (w_alarm_minute),
        .o_idle         (w_entry_idle),
        .o_res          (w_entry_res)
    );

    mwc_window u_window (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_fire),
        .i_op            (r_in_op),
        .i_cur_hour      (r_in_data[12:8]),
        .i_cur_minute    (r_in_data[18:13]),
        .i_music_playing (r_in_data[19]),
        .i_alarm_hour    (w_alarm_hour),
        .i_alarm_minute  (w_alarm_minute),
        .i_entry_idle    (w_entry_idle),
        .i_half_window   (w_half),
        .i_grace         (w_grace),
        .o_cmd           (w_cmd)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_fire) begin
            r_out_data <= {1'b0, w_cmd.box_open, w_cmd.lamp_action, w_cmd.send_sms,
                           w_cmd.pause_music, w_cmd.start_music,
                           w_entry_res.entry_phase, w_entry_res.alarm_minute,
                           w_entry_res.alarm_hour, w_entry_res.reply_code};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // A held request is never dropped while the result side is stalled.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> r_in_valid)
        else $error("top: pending request lost");
    // A request is only processed when its result has somewhere to go.
    a_fire_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("top: processed request left no result");
    // Music is never started and paused by the same request.
    a_music_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[17] && r_out_data[18]))
        else $error("top: music started and paused together");
`endif

endmodule
